[hw/rtl/mdmf_pkg.sv]
// Package for the masked disc mean filter: sizes, codes, payload and state types.
// Used by mdmf_store, mdmf_divider and masked_disc_mean_filter_unit.
package mdmf_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int PIXEL_BITS = 16;
	localparam int MAX_RADIUS = 7;

	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
	localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
	localparam int DIM_BITS   = 9;
	localparam int R2_BITS    = 6;
	localparam int R2_MAX     = MAX_RADIUS * MAX_RADIUS;
	localparam int OFF_BITS   = $clog2(MAX_RADIUS + 1) + 1;
	localparam int SQ_BITS    = 2 * OFF_BITS + 1;
	localparam int COORD_BITS = 10;
	localparam int CNT_BITS   = 8;
	localparam int MAX_COUNT  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int SUM_BITS   = PIXEL_BITS + CNT_BITS;
	localparam int MEAN_BITS  = 16;
	localparam int STEP_BITS  = $clog2(SUM_BITS);
	localparam int CFG_IDX_BITS = 2;

	localparam logic signed [OFF_BITS-1:0] MAX_OFF = OFF_BITS'(MAX_RADIUS);

	typedef enum logic {
		CMD_WRITE   = 1'b0,
		CMD_COMPUTE = 1'b1
	} mdmf_cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_IMAGE_WIDTH    = 2'd0,
		CFG_IMAGE_HEIGHT   = 2'd1,
		CFG_RADIUS_SQUARED = 2'd2,
		CFG_MASK_ENABLE    = 2'd3
	} mdmf_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTRE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} mdmf_state_t;

	typedef struct packed {
		mdmf_cmd_t       command;
		logic [7:0]      column;
		logic [7:0]      row;
		logic [15:0]     pixel_value;
		logic            mask_bit;
	} mdmf_in_t;

	typedef struct packed {
		logic [15:0] mean_value;
		logic [7:0]  neighbours_counted;
		logic [7:0]  result_column;
		logic [7:0]  result_row;
	} mdmf_out_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic                  mask;
	} mdmf_entry_t;

endpackage

[hw/rtl/masked_disc_mean_filter_unit.sv]
// Top level of the masked disc mean filter: sequencer, disc scan, accumulator, output register.
// Depends on mdmf_pkg, mdmf_store and mdmf_divider.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_data  (mdmf_in_t)
// out      output     out_valid / out_stall  out_data (mdmf_out_t)
// cfg      input      cfg_write              cfg_index, cfg_data
//
// A write transaction is accepted without a stall. A compute transaction stalls the input
// after its accepting edge for a centre read, a disc scan through the single store port,
// a drain state, the divider (start, 24 quotient bits, done) and an output load.
// A centre outside the image goes straight to the output load; a masked-out one after its read.
// Reset clears control state and sets the registers to their defaults; the store is not cleared.
// A result waits in the output register while the next transaction runs; a later result
// finding that register full and stalled holds the input stalled until it can load.
module masked_disc_mean_filter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  mdmf_pkg::mdmf_in_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output mdmf_pkg::mdmf_out_t                  out_data,
	input  logic                                 cfg_write,
	input  logic [mdmf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mdmf_pkg::DIM_BITS-1:0]        cfg_data
);

	mdmf_pkg::mdmf_state_t state_q, state_d;

	logic [mdmf_pkg::DIM_BITS-1:0] cfg_w_q, cfg_h_q;
	logic [mdmf_pkg::R2_BITS-1:0]  cfg_r2_q;
	logic                          cfg_mask_q;

	logic [7:0]                          col_q, row_q;
	logic signed [mdmf_pkg::OFF_BITS-1:0] dx_q, dy_q;
	logic [mdmf_pkg::SUM_BITS-1:0]       sum_q;
	logic [mdmf_pkg::CNT_BITS-1:0]       count_q;
	logic [mdmf_pkg::MEAN_BITS-1:0]      res_mean_q;
	logic                                pend_s1;
	logic                                out_valid_q;
	mdmf_pkg::mdmf_out_t                 out_data_q;

	logic [mdmf_pkg::DIM_BITS-1:0]       w_eff, h_eff;
	logic [mdmf_pkg::R2_BITS-1:0]        r2_eff;
	logic signed [mdmf_pkg::COORD_BITS-1:0] nx, ny;
	logic signed [2*mdmf_pkg::OFF_BITS-1:0] sq_x, sq_y;
	logic [mdmf_pkg::SQ_BITS-1:0]        dsq;
	logic                                include_n, scan_last, hit;
	logic                                in_acc, centre_in, write_in_range, load_out;

	logic                                mem_we;
	logic [mdmf_pkg::ADDR_BITS-1:0]      mem_addr;
	mdmf_pkg::mdmf_entry_t               mem_wdata, mem_rdata;

	logic                                div_start;
	logic                                div_done;
	logic [mdmf_pkg::SUM_BITS-1:0]       quotient;

	assign w_eff  = (cfg_w_q > mdmf_pkg::DIM_BITS'(mdmf_pkg::MAX_WIDTH)) ?
		mdmf_pkg::DIM_BITS'(mdmf_pkg::MAX_WIDTH) : cfg_w_q;
	assign h_eff  = (cfg_h_q > mdmf_pkg::DIM_BITS'(mdmf_pkg::MAX_HEIGHT)) ?
		mdmf_pkg::DIM_BITS'(mdmf_pkg::MAX_HEIGHT) : cfg_h_q;
	assign r2_eff = (cfg_r2_q > mdmf_pkg::R2_BITS'(mdmf_pkg::R2_MAX)) ?
		mdmf_pkg::R2_BITS'(mdmf_pkg::R2_MAX) : cfg_r2_q;

	assign nx   = $signed({2'b00, col_q}) + mdmf_pkg::COORD_BITS'(dx_q);
	assign ny   = $signed({2'b00, row_q}) + mdmf_pkg::COORD_BITS'(dy_q);
	assign sq_x = (2*mdmf_pkg::OFF_BITS)'(dx_q) * (2*mdmf_pkg::OFF_BITS)'(dx_q);
	assign sq_y = (2*mdmf_pkg::OFF_BITS)'(dy_q) * (2*mdmf_pkg::OFF_BITS)'(dy_q);
	assign dsq  = {1'b0, sq_x} + {1'b0, sq_y};

	assign include_n = (dsq <= mdmf_pkg::SQ_BITS'(r2_eff))
		&& !nx[mdmf_pkg::COORD_BITS-1] && (nx[mdmf_pkg::DIM_BITS-1:0] < w_eff)
		&& !ny[mdmf_pkg::COORD_BITS-1] && (ny[mdmf_pkg::DIM_BITS-1:0] < h_eff);
	assign scan_last = (dx_q == mdmf_pkg::MAX_OFF) && (dy_q == mdmf_pkg::MAX_OFF);
	assign hit       = pend_s1 && (!cfg_mask_q || mem_rdata.mask);

	assign in_stall  = (state_q != mdmf_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign centre_in = ({1'b0, in_data.column} < w_eff) && ({1'b0, in_data.row} < h_eff);
	assign write_in_range = ({1'b0, in_data.column} < mdmf_pkg::DIM_BITS'(mdmf_pkg::MAX_WIDTH))
		&& ({1'b0, in_data.row} < mdmf_pkg::DIM_BITS'(mdmf_pkg::MAX_HEIGHT));
	assign load_out  = (state_q == mdmf_pkg::ST_FINISH) && (!out_valid_q || !out_stall);

	assign mem_we          = in_acc && (in_data.command == mdmf_pkg::CMD_WRITE) && write_in_range;
	assign mem_wdata.pixel = mdmf_pkg::PIXEL_BITS'(in_data.pixel_value);
	assign mem_wdata.mask  = in_data.mask_bit;
	assign mem_addr = (state_q == mdmf_pkg::ST_IDLE) ? {in_data.row, in_data.column} :
		{ny[7:0], nx[7:0]};

	assign div_start = (state_q == mdmf_pkg::ST_DIV_GO);

	mdmf_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	mdmf_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mdmf_pkg::ST_IDLE: begin
				if (in_acc && (in_data.command == mdmf_pkg::CMD_COMPUTE)) begin
					state_d = centre_in ? mdmf_pkg::ST_CENTRE : mdmf_pkg::ST_FINISH;
				end
			end
			mdmf_pkg::ST_CENTRE: begin
				state_d = (cfg_mask_q && !mem_rdata.mask) ? mdmf_pkg::ST_FINISH :
					mdmf_pkg::ST_SCAN;
			end
			mdmf_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = mdmf_pkg::ST_DRAIN;
				end
			end
			mdmf_pkg::ST_DRAIN:   state_d = mdmf_pkg::ST_DIV_GO;
			mdmf_pkg::ST_DIV_GO:  state_d = mdmf_pkg::ST_DIV_WAIT;
			mdmf_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = mdmf_pkg::ST_FINISH;
				end
			end
			mdmf_pkg::ST_FINISH: begin
				if (load_out) begin
					state_d = mdmf_pkg::ST_IDLE;
				end
			end
			default: state_d = mdmf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q    <= mdmf_pkg::DIM_BITS'(256);
			cfg_h_q    <= mdmf_pkg::DIM_BITS'(256);
			cfg_r2_q   <= mdmf_pkg::R2_BITS'(1);
			cfg_mask_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				mdmf_pkg::CFG_IMAGE_WIDTH:    cfg_w_q    <= cfg_data;
				mdmf_pkg::CFG_IMAGE_HEIGHT:   cfg_h_q    <= cfg_data;
				mdmf_pkg::CFG_RADIUS_SQUARED: cfg_r2_q   <= cfg_data[mdmf_pkg::R2_BITS-1:0];
				mdmf_pkg::CFG_MASK_ENABLE:    cfg_mask_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == mdmf_pkg::ST_SCAN) && include_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mdmf_pkg::ST_IDLE: begin
				col_q      <= in_data.column;
				row_q      <= in_data.row;
				res_mean_q <= '0;
				count_q    <= '0;
			end
			mdmf_pkg::ST_CENTRE: begin
				res_mean_q <= mdmf_pkg::MEAN_BITS'(mem_rdata.pixel);
				count_q    <= '0;
				sum_q      <= '0;
				dx_q       <= -mdmf_pkg::MAX_OFF;
				dy_q       <= -mdmf_pkg::MAX_OFF;
			end
			mdmf_pkg::ST_SCAN: begin
				if (dx_q == mdmf_pkg::MAX_OFF) begin
					dx_q <= -mdmf_pkg::MAX_OFF;
					dy_q <= dy_q + 1'b1;
				end else begin
					dx_q <= dx_q + 1'b1;
				end
				if (hit) begin
					sum_q   <= sum_q + mdmf_pkg::SUM_BITS'(mem_rdata.pixel);
					count_q <= count_q + 1'b1;
				end
			end
			mdmf_pkg::ST_DRAIN: begin
				if (hit) begin
					sum_q   <= sum_q + mdmf_pkg::SUM_BITS'(mem_rdata.pixel);
					count_q <= count_q + 1'b1;
				end
			end
			mdmf_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					res_mean_q <= (count_q == '0) ? '0 : quotient[mdmf_pkg::MEAN_BITS-1:0];
				end
			end
			default: ;
		endcase
		if (load_out) begin
			out_data_q.mean_value         <= res_mean_q;
			out_data_q.neighbours_counted <= count_q;
			out_data_q.result_column      <= col_q;
			out_data_q.result_row         <= row_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mdmf_pkg::ST_IDLE) |-> (count_q <= mdmf_pkg::CNT_BITS'(mdmf_pkg::MAX_COUNT)))
		else $error("neighbour count exceeds disc size");

	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == mdmf_pkg::ST_SCAN || state_q == mdmf_pkg::ST_DRAIN))
		else $error("pending read outside disc scan");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == mdmf_pkg::ST_DIV_WAIT))
		else $error("divider finished outside wait state");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == mdmf_pkg::ST_FINISH))
		else $error("result presented without finishing a transaction");

endmodule

[hw/rtl/mdmf_store.sv]
// Pixel and mask store: one port, read each cycle and written when enabled, read data registered.
// Depends on mdmf_pkg for the entry type and address width.
module mdmf_store (
	input  logic                           clk,
	input  logic                           we,
	input  logic [mdmf_pkg::ADDR_BITS-1:0] addr,
	input  mdmf_pkg::mdmf_entry_t          wdata,
	output mdmf_pkg::mdmf_entry_t          rdata
);

	mdmf_pkg::mdmf_entry_t mem [2**mdmf_pkg::ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[hw/rtl/mdmf_divider.sv]
// Restoring divider that retires one quotient bit per cycle.
// Depends on mdmf_pkg for the sum and count widths.
module mdmf_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mdmf_pkg::SUM_BITS-1:0] dividend,
	input  logic [mdmf_pkg::CNT_BITS-1:0] divisor,
	output logic                          done,
	output logic [mdmf_pkg::SUM_BITS-1:0] quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [mdmf_pkg::STEP_BITS-1:0] step_q;
	logic [mdmf_pkg::CNT_BITS-1:0]  rem_q;
	logic [mdmf_pkg::CNT_BITS-1:0]  div_q;
	logic [mdmf_pkg::SUM_BITS-1:0]  quo_q;
	logic [mdmf_pkg::CNT_BITS:0]    shifted;
	logic [mdmf_pkg::CNT_BITS:0]    diff;
	logic                           fits;

	assign shifted = {rem_q, quo_q[mdmf_pkg::SUM_BITS-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == mdmf_pkg::STEP_BITS'(mdmf_pkg::SUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[mdmf_pkg::CNT_BITS-1:0] : shifted[mdmf_pkg::CNT_BITS-1:0];
			quo_q <= {quo_q[mdmf_pkg::SUM_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
